// ----- design/sdta_pkg.sv -----
// shared types and character codes for the signed decimal to ascii core
package sdta_pkg;

   typedef logic [7:0] char_type;

   localparam char_type ASCII_ZERO  = 8'h30;
   localparam char_type ASCII_MINUS = 8'h2D;
   localparam int       DEC_MAX     = 9;

endpackage

// ----- design/signed_decimal_to_ascii_core.sv -----
// signed integer to decimal ascii character stream, one character per item
//
// req channel: one signed integer per item in req_tdata (low VALUE_WIDTH bits).
// rsp channel: the decimal characters, most significant first, a leading '-'
// for negative values, no leading zeros; rsp_tlast marks the final character.
// a conversion is a shift-and-add-3 pass through one shared bcd adjust unit,
// one input bit per cycle in the S_CONV state, then S_FIND locates the
// leading digit, then one character per cycle (sign first) while the receiver
// takes them. req_tready is low while an item is in the block and returns high
// as the final character enters the output register, so the next input item
// is taken while that character still waits.
// a stalled receiver holds the output register and pauses the sequencer.
// reset (synchronous, active high) returns to idle with no character pending.
module signed_decimal_to_ascii_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // char_code
   output logic                                 rsp_tlast
);

   localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_FIND = 3'd2;
   localparam logic [2:0] S_SIGN = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [VALUE_WIDTH-1:0]           mag_ff, mag_in;
   logic [NUM_DIGITS-1:0][3:0]       bcd_ff, bcd_in;
   logic                             neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [DIG_IDX_W-1:0]             dig_cnt_ff, dig_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sdta_pkg::char_type               rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0]           raw;
   logic [NUM_DIGITS-1:0][3:0]       adj;
   logic [BCD_W-1:0]                 shift_full;
   logic [DIG_IDX_W-1:0]             lead_idx;
   logic                             out_free;
   logic                             accept;

   assign raw        = req_tdata[VALUE_WIDTH-1:0];
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // bcd adjust unit, shared over all bit steps
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   assign shift_full = BCD_W'({adj, mag_ff[VALUE_WIDTH-1]});

   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            lead_idx = DIG_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in     = raw[VALUE_WIDTH-1];
               mag_in     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH - 1);
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            bcd_in     = shift_full;
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            dig_cnt_in = lead_idx;
            state_in   = neg_ff ? S_SIGN : S_EMIT;
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sdta_pkg::ASCII_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sdta_pkg::ASCII_ZERO | {4'd0, bcd_ff[dig_cnt_ff]};
               rsp_last_in  = (dig_cnt_ff == '0);
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- design/sdta_checker.sv -----
// port level checks for the signed decimal to ascii core, with its bind
module sdta_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled item changed");

   // busy after taking a number
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // only sign or digit characters
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == sdta_pkg::ASCII_MINUS) ||
                     ((rsp_tdata >= sdta_pkg::ASCII_ZERO) &&
                      (rsp_tdata <= sdta_pkg::ASCII_ZERO + 8'(sdta_pkg::DEC_MAX))))
      else $error("bad character code");

   // sign never closes a number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == sdta_pkg::ASCII_MINUS) |-> !rsp_tlast)
      else $error("sign marked last");

   // nothing pending after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind signed_decimal_to_ascii_core sdta_checker u_sdta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- verif/tb_signed_decimal_to_ascii_core.sv -----
// testbench for signed_decimal_to_ascii_core: directed and random integers checked per character
module tb_signed_decimal_to_ascii_core;

   localparam int VALUE_WIDTH   = 32;
   localparam int DATA_WIDTH    = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int DEC_BASE      = 10;
   localparam int RANDOM_ITEMS  = 500;
   localparam int QUIET_ITEMS   = 60;
   localparam int PRESSURE_AT   = 120;
   localparam int PRESSURE_LEN  = 400;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_DIRECTED  = 20;

   typedef struct {
      sdta_pkg::char_type code;
      logic               last;
   } char_item_type;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      string                  text;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata = '0;  // value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;       // char_code
   logic                  rsp_tlast;

   char_item_type pending_chars[$];
   int            error_count    = 0;
   int            accepted_count = 0;
   int            cycle_count    = 0;
   bit            quiet_phase    = 1'b0;

   // empty text means the row is checked against the decimal formatter
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{-32'sd1,        "-1"},
      '{32'h7FFFFFFF,   "2147483647"},
      '{32'h80000000,   "-2147483648"},
      '{32'h80000001,   ""},
      '{32'd9,          ""},
      '{32'd10,         ""},
      '{-32'sd9,        ""},
      '{-32'sd10,       ""},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd999999999,  ""},
      '{32'd1000000000, ""},
      '{-32'sd999999999, ""},
      '{-32'sd1000000000, ""},
      '{32'd12345,      ""},
      '{-32'sd67890,    ""},
      '{32'h55555555,   ""},
      '{32'hAAAAAAAA,   ""}
   };

   signed_decimal_to_ascii_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic void queue_decimal_chars(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH:0] magnitude;
      sdta_pkg::char_type   digits[$];
      logic                 negative;
      negative  = value[VALUE_WIDTH-1];
      magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
      do begin
         digits.push_front(sdta_pkg::ASCII_ZERO +
                           sdta_pkg::char_type'(magnitude % DEC_BASE));
         magnitude = magnitude / DEC_BASE;
      end while (magnitude != 0);
      if (negative) begin
         pending_chars.push_back('{sdta_pkg::ASCII_MINUS, 1'b0});
      end
      foreach (digits[i]) begin
         pending_chars.push_back('{digits[i], i == digits.size() - 1});
      end
   endfunction

   function automatic void queue_text_chars(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{sdta_pkg::char_type'(text[i]), i == text.len() - 1});
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0] scale;
      scale = 1;
      case ($urandom_range(0, 3))
         0: value = $urandom;
         1: begin
            repeat ($urandom_range(1, 9)) scale = scale * DEC_BASE;
            value = $urandom % scale;
         end
         2: begin
            repeat ($urandom_range(1, 9)) scale = scale * DEC_BASE;
            value = scale - $urandom_range(0, 2);
         end
         default: value = $urandom_range(0, 20);
      endcase
      if (!value[VALUE_WIDTH-1] && $urandom_range(0, 1)) begin
         value = -value;
      end
      return value;
   endfunction

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input string text);
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_WIDTH'(value);
      do @(posedge clock); while (!req_tready);
      accepted_count++;
      if (text.len() != 0) begin
         queue_text_chars(text);
      end else begin
         queue_decimal_chars(value);
      end
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      char_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item code=%h last=%b", $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.code) begin
               error_count++;
               $display("%0t: char_code expected %h actual %h", $time, want.code, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      @(negedge reset);
      forever begin
         if (quiet_phase) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            rsp_tready <= 1'b0;
            repeat (PRESSURE_LEN) @(posedge clock);
            pressure_done = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].text);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_phase = 1'b1;
         end
         send_value(random_value(), "");
      end
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/sdta_pkg.sv
design/signed_decimal_to_ascii_core.sv
design/sdta_checker.sv
verif/tb_signed_decimal_to_ascii_core.sv
